// ----- hw/rtl/tmpu_pkg.sv -----
// ----------------------------------------------------------------------------
// Trapezoid motion profile unit: shared types
// Item layouts for the request and result channels, the configuration
// register set, and the widths of the fixed-point quantities.
// ----------------------------------------------------------------------------
package tmpu_pkg;

  // Position in whole counts, speed in unsigned 16.8, fine position in s25.8.
  localparam int unsigned PosW   = 24;
  localparam int unsigned SpeedW = 24;
  localparam int unsigned SpdAccW = 25;
  localparam int unsigned FineW  = 33;
  localparam int unsigned FracW  = 8;

  // Request codes.
  localparam logic [1:0] ReqTick  = 2'd0;
  localparam logic [1:0] ReqStart = 2'd1;
  localparam logic [1:0] ReqAbort = 2'd2;
  localparam logic [1:0] ReqNone  = 2'd3;

  // Event codes.
  localparam logic [1:0] EvNone   = 2'd0;
  localparam logic [1:0] EvDone   = 2'd1;
  localparam logic [1:0] EvAbort  = 2'd2;
  localparam logic [1:0] EvReject = 2'd3;

  // Configuration register indexes.
  localparam logic RegAccelStep = 1'b0;
  localparam logic RegTopSpeed  = 1'b1;

  // One request item.
  typedef struct packed {
    logic [1:0]               req_type;
    logic                     profile_mode;
    logic signed [PosW-1:0]   target_position;
    logic [SpeedW-1:0]        move_speed;
    logic                     torque_hold;
  } tmpu_in_t;

  // One result item.
  typedef struct packed {
    logic signed [PosW-1:0] cmd_position;
    logic                   busy_res;
    logic [1:0]             event_res;
  } tmpu_out_t;

  // Configuration register set.
  typedef struct packed {
    logic [SpeedW-1:0] accel_step;
    logic [SpeedW-1:0] top_speed;
  } tmpu_cfg_t;

endpackage

// ----- hw/rtl/tmpu_cfg.sv -----
// ----------------------------------------------------------------------------
// Trapezoid motion profile unit: configuration registers
// Holds the acceleration step and the top speed, written through a plain
// write port.
// ----------------------------------------------------------------------------
module tmpu_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [tmpu_pkg::SpeedW-1:0]     cfg_wdata_i,
  output tmpu_pkg::tmpu_cfg_t             cfg_o
);

  localparam logic RegAccelStep = tmpu_pkg::RegAccelStep;
  localparam logic RegTopSpeed  = tmpu_pkg::RegTopSpeed;

  localparam logic [tmpu_pkg::SpeedW-1:0] AccelReset = 24'd256;
  localparam logic [tmpu_pkg::SpeedW-1:0] TopReset   = 24'd65536;

  tmpu_pkg::tmpu_cfg_t cfg_q;

  // Register write decode.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.accel_step <= AccelReset;
      cfg_q.top_speed  <= TopReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegAccelStep: cfg_q.accel_step <= cfg_wdata_i;
        RegTopSpeed:  cfg_q.top_speed  <= cfg_wdata_i;
        default:      cfg_q.top_speed  <= cfg_q.top_speed;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/tmpu_in_stage.sv -----
// ----------------------------------------------------------------------------
// Trapezoid motion profile unit: input register
// Captures one request item and holds it until the profile core takes it.
// ----------------------------------------------------------------------------
module tmpu_in_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tmpu_pkg::tmpu_in_t   in_item_i,
  output logic                 item_vld_o,
  output tmpu_pkg::tmpu_in_t   item_o,
  input  logic                 item_take_i
);

  logic               vld_q;
  tmpu_pkg::tmpu_in_t item_q;
  logic               load;

  // The register frees up in the same cycle the core takes its item.
  assign in_ready_o = !vld_q || item_take_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load) begin
      vld_q <= 1'b1;
    end else if (item_take_i) begin
      vld_q <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign item_vld_o = vld_q;
  assign item_o     = item_q;

endmodule

// ----- hw/rtl/tmpu_core.sv -----
// ----------------------------------------------------------------------------
// Trapezoid motion profile unit: profile core
// Holds the move state, applies one request item per cycle while the result
// register is free or draining, and registers the result item.
// ----------------------------------------------------------------------------
module tmpu_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tmpu_pkg::tmpu_cfg_t  cfg_i,
  input  logic                 item_vld_i,
  input  tmpu_pkg::tmpu_in_t   item_i,
  output logic                 item_take_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tmpu_pkg::tmpu_out_t  out_item_o
);

  localparam int unsigned PosW  = tmpu_pkg::PosW;
  localparam int unsigned SpdW  = tmpu_pkg::SpdAccW;
  localparam int unsigned FineW = tmpu_pkg::FineW;
  localparam int unsigned FracW = tmpu_pkg::FracW;

  // Phase codes.
  localparam logic [2:0] PhIdle      = 3'd0;
  localparam logic [2:0] PhUp        = 3'd1;
  localparam logic [2:0] PhCruise    = 3'd2;
  localparam logic [2:0] PhDownFirst = 3'd3;
  localparam logic [2:0] PhDown      = 3'd4;
  localparam logic [2:0] PhRect      = 3'd5;

  // Request codes.
  localparam logic [1:0] ReqTick  = tmpu_pkg::ReqTick;
  localparam logic [1:0] ReqStart = tmpu_pkg::ReqStart;
  localparam logic [1:0] ReqAbort = tmpu_pkg::ReqAbort;

  // Event codes.
  localparam logic [1:0] EvNone   = tmpu_pkg::EvNone;
  localparam logic [1:0] EvDone   = tmpu_pkg::EvDone;
  localparam logic [1:0] EvAbort  = tmpu_pkg::EvAbort;
  localparam logic [1:0] EvReject = tmpu_pkg::EvReject;

  // Move state.
  logic signed [PosW-1:0]  cmd_q, cmd_d;
  logic signed [FineW-1:0] fine_q, fine_d;
  logic [SpdW-1:0]         speed_q, speed_d;
  logic                    neg_q, neg_d;
  logic signed [PosW-1:0]  origin_q, origin_d;
  logic signed [PosW-1:0]  goal_q, goal_d;
  logic signed [PosW-1:0]  mark_q, mark_d;
  logic [2:0]              phase_q, phase_d;
  logic [1:0]              event_d;

  // Result register.
  logic                 out_vld_q;
  tmpu_pkg::tmpu_out_t  out_q;

  logic step_en;
  logic busy;

  // Tick datapath.
  logic [SpdW-1:0]         speed_up, speed_dn, step_speed;
  logic signed [FineW-1:0] fine_adv;
  logic signed [PosW:0]    whole;
  logic signed [PosW:0]    goal_w;
  logic signed [PosW-1:0]  whole24;
  logic                    hit_goal, hit_mark, top_hit, low_speed;
  logic signed [PosW+1:0]  mirror;

  // Start datapath.
  logic signed [PosW:0]    diff_w, half_w, mark_start;
  logic signed [FineW-1:0] fine_start;
  logic                    neg_start;

  // An item is taken when the result register is free or drains this cycle.
  assign step_en     = item_vld_i && (!out_vld_q || out_ready_i);
  assign item_take_o = step_en;
  assign busy        = (phase_q != PhIdle);

  // Speed for this tick: ramp up, ramp down, or hold.
  assign speed_up = speed_q + {1'b0, cfg_i.accel_step};
  assign speed_dn = speed_q - {1'b0, cfg_i.accel_step};

  always_comb begin
    case (phase_q)
      PhUp:    step_speed = speed_up;
      PhDown:  step_speed = speed_dn;
      default: step_speed = speed_q;
    endcase
  end

  // Advance the fine position and compare against goal and ramp mark.
  assign fine_adv = neg_q ? (fine_q - $signed({{(FineW-SpdW){1'b0}}, step_speed}))
                          : (fine_q + $signed({{(FineW-SpdW){1'b0}}, step_speed}));
  assign whole    = $signed(fine_adv[FineW-1:FracW]);
  assign goal_w   = (PosW+1)'(goal_q);
  assign whole24  = $signed(whole[PosW-1:0]);
  assign hit_goal = neg_q ? (whole <= goal_w) : (whole >= goal_w);
  assign hit_mark = neg_q ? (whole24 <= mark_q) : (whole24 >= mark_q);
  assign top_hit  = (step_speed >= {1'b0, cfg_i.top_speed});
  assign low_speed = (step_speed < {1'b0, cfg_i.accel_step});
  assign mirror   = (PosW+2)'(origin_q) - (PosW+2)'(whole24) + (PosW+2)'(goal_q);

  // Midpoint of the move, halved with rounding toward zero.
  assign diff_w     = (PosW+1)'(item_i.target_position) - (PosW+1)'(cmd_q);
  assign half_w     = $signed(diff_w + {{PosW{1'b0}}, diff_w[PosW]}) >>> 1;
  assign mark_start = half_w + (PosW+1)'(cmd_q);
  assign fine_start = {cmd_q[PosW-1], cmd_q, {FracW{1'b0}}};
  assign neg_start  = ($signed(item_i.target_position) < cmd_q);

  // Next move state for the item in the input register.
  always_comb begin
    cmd_d    = cmd_q;
    fine_d   = fine_q;
    speed_d  = speed_q;
    neg_d    = neg_q;
    origin_d = origin_q;
    goal_d   = goal_q;
    mark_d   = mark_q;
    phase_d  = phase_q;
    event_d  = EvNone;

    unique case (item_i.req_type)
      ReqTick: begin
        if (busy && !item_i.torque_hold) begin
          fine_d  = fine_adv;
          speed_d = step_speed;
          if (hit_goal) begin
            cmd_d   = goal_q;
            phase_d = PhIdle;
            speed_d = '0;
            event_d = EvDone;
          end else begin
            cmd_d = whole24;
            unique case (phase_q) inside
              PhUp: begin
                if (hit_mark) begin
                  phase_d = PhDownFirst;
                end else if (top_hit) begin
                  mark_d  = mirror[PosW-1:0];
                  phase_d = PhCruise;
                end
              end
              PhCruise: begin
                if (hit_mark) begin
                  phase_d = PhDownFirst;
                end
              end
              PhDownFirst, PhDown: begin
                if (low_speed) begin
                  cmd_d   = goal_q;
                  phase_d = PhIdle;
                  speed_d = '0;
                  event_d = EvDone;
                end else begin
                  phase_d = PhDown;
                end
              end
              default: begin
                phase_d = phase_q;
              end
            endcase
          end
        end
      end
      ReqStart: begin
        if (busy) begin
          event_d = EvReject;
        end else begin
          origin_d = cmd_q;
          fine_d   = fine_start;
          goal_d   = item_i.target_position;
          neg_d    = neg_start;
          if (item_i.profile_mode == 1'b0) begin
            mark_d  = mark_start[PosW-1:0];
            speed_d = '0;
            phase_d = PhUp;
          end else begin
            speed_d = {1'b0, item_i.move_speed};
            phase_d = PhRect;
          end
        end
      end
      ReqAbort: begin
        if (busy) begin
          phase_d = PhIdle;
          speed_d = '0;
          event_d = EvAbort;
        end
      end
      default: begin
        event_d = EvNone;
      end
    endcase
  end

  // Move state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q    <= '0;
      fine_q   <= '0;
      speed_q  <= '0;
      neg_q    <= 1'b0;
      origin_q <= '0;
      goal_q   <= '0;
      mark_q   <= '0;
      phase_q  <= PhIdle;
    end else if (step_en) begin
      cmd_q    <= cmd_d;
      fine_q   <= fine_d;
      speed_q  <= speed_d;
      neg_q    <= neg_d;
      origin_q <= origin_d;
      goal_q   <= goal_d;
      mark_q   <= mark_d;
      phase_q  <= phase_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step_en) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (step_en) begin
      out_q.cmd_position <= cmd_d;
      out_q.busy_res     <= (phase_d != PhIdle);
      out_q.event_res    <= event_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  // An idle profile never keeps a speed.
  a_idle_speed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhIdle) |-> (speed_q == '0))
    else $error("speed left over while idle");

  // The down ramp never runs below one acceleration step.
  a_down_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhDown) |-> (speed_q >= {1'b0, cfg_i.accel_step}))
    else $error("down ramp speed below acceleration step");

  // A finished move reports idle and sits on its goal.
  a_done_at_goal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_q.event_res == EvDone)) |->
      (!out_q.busy_res && (out_q.cmd_position == goal_q)))
    else $error("finished move not at goal");

  // A rejected start only happens while a move is running.
  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_q.event_res == EvReject)) |-> out_q.busy_res)
    else $error("start rejected while idle");

  // An abort or a finish leaves the profile idle.
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en && ((event_d == EvAbort) || (event_d == EvDone))) |=> (phase_q == PhIdle))
    else $error("move still running after it ended");

endmodule

// ----- hw/rtl/trapezoid_motion_profile_unit.sv -----
// ----------------------------------------------------------------------------
// Trapezoid motion profile unit
// Generates a trapezoidal or rectangular speed profile for one axis and
// reports the commanded position after every request item.
//
//   Channel   Direction  Handshake               Payload
//   in        input      in_valid_i / in_ready_o  tmpu_in_t   (request item)
//   out       output     out_valid_o / out_ready_i tmpu_out_t (result item)
//   cfg       input      cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// One item per cycle sustained while results are taken; each item's result
// passes through the input register, then the single tick/start pass into
// the result register. That pass, the speed add, position add and compares,
// sets the cycle time.
// Reset clears the move state to idle at position zero; no clearing pass.
// A stalled result holds in its register while the next item waits in the
// input register.
// ----------------------------------------------------------------------------
module trapezoid_motion_profile_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  tmpu_pkg::tmpu_in_t           in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output tmpu_pkg::tmpu_out_t          out_item_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [tmpu_pkg::SpeedW-1:0]  cfg_wdata_i
);

  tmpu_pkg::tmpu_cfg_t cfg;
  tmpu_pkg::tmpu_in_t  item;
  logic                item_vld;
  logic                item_take;

  // Configuration registers.
  tmpu_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Input register.
  tmpu_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .item_vld_o  (item_vld),
    .item_o      (item),
    .item_take_i (item_take)
  );

  // Profile core and result register.
  tmpu_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .item_vld_i  (item_vld),
    .item_i      (item),
    .item_take_o (item_take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
